// ===== hw/rtl/record_varint_encoder_top_assert.svh =====
// ----------------------------------------------------------------------------
// Record varint encoder assertion macros
// Shared concurrent assertion forms, clocked on aclk, off during reset.
// ----------------------------------------------------------------------------
`ifndef RECORD_VARINT_ENCODER_TOP_ASSERT_SVH
`define RECORD_VARINT_ENCODER_TOP_ASSERT_SVH

// Condition that holds on every cycle out of reset.
`define RVE_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// Same-cycle implication.
`define RVE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RVE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/rve_pkg.sv =====
// ----------------------------------------------------------------------------
// Record varint encoder package
// Shared constants, command/status types and varint helpers.
// ----------------------------------------------------------------------------
package rve_pkg;

    localparam logic [23:0] MAX_VALUE_BYTES = 24'hFF_FFFF;

    localparam logic OP_HEADER  = 1'b0;
    localparam logic OP_PAYLOAD = 1'b1;

    // Output byte source select
    localparam logic [1:0] SEL_CUR  = 2'd0;
    localparam logic [1:0] SEL_ZERO = 2'd1;
    localparam logic [1:0] SEL_PAY  = 2'd2;
    localparam logic [1:0] SEL_ERR  = 2'd3;

    typedef struct packed {
        logic       out_load;
        logic [1:0] out_sel;
        logic       out_end;
        logic       out_last;
        logic       hdr_load;
        logic       pay_take;
        logic       cur_shift;
        logic       cur_load_off;
        logic       cur_load_len;
    } rve_cmd_t;

    typedef struct packed {
        logic adv;
        logic rec_open;
        logic rem_zero;
        logic rem_one;
        logic cur_fits;
        logic vlen_bad;
    } rve_sts_t;

    // Number of 7-bit groups a varint of v needs (1 to 5).
    function automatic logic [2:0] varint_len(input logic [31:0] v);
        logic [2:0] n;
        if (v[31:28] != 4'd0) begin
            n = 3'd5;
        end else if (v[27:21] != 7'd0) begin
            n = 3'd4;
        end else if (v[20:14] != 7'd0) begin
            n = 3'd3;
        end else if (v[13:7] != 7'd0) begin
            n = 3'd2;
        end else begin
            n = 3'd1;
        end
        return n;
    endfunction

endpackage

// ===== hw/rtl/rve_ctrl.sv =====
// ----------------------------------------------------------------------------
// Record varint encoder controller
// Sequences the record fields and issues commands to the datapath.
// ----------------------------------------------------------------------------
`include "record_varint_encoder_top_assert.svh"

module rve_ctrl
    import rve_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    input  logic     s_tuser,
    output logic     s_tready,
    input  rve_sts_t sts,
    output rve_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_BODY = 3'd1;
    localparam logic [2:0] ST_ATTR = 3'd2;
    localparam logic [2:0] ST_TS   = 3'd3;
    localparam logic [2:0] ST_OFF  = 3'd4;
    localparam logic [2:0] ST_KEY  = 3'd5;
    localparam logic [2:0] ST_LEN  = 3'd6;
    localparam logic [2:0] ST_HCNT = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       len_empty_done;

    assign s_tready = (state_reg == ST_IDLE) && sts.adv;

    assign len_empty_done = (state_reg == ST_LEN) && sts.adv && sts.cur_fits && !sts.rec_open;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && sts.adv) begin
                    if (s_tuser == OP_HEADER) begin
                        if (sts.rec_open || sts.vlen_bad) begin
                            cmd.out_load = 1'b1;
                            cmd.out_sel  = SEL_ERR;
                            cmd.out_last = 1'b1;
                        end else begin
                            cmd.hdr_load = 1'b1;
                            state_next   = ST_BODY;
                        end
                    end else begin
                        if (!sts.rec_open || sts.rem_zero) begin
                            cmd.out_load = 1'b1;
                            cmd.out_sel  = SEL_ERR;
                            cmd.out_last = 1'b1;
                        end else begin
                            cmd.pay_take = 1'b1;
                            cmd.out_load = 1'b1;
                            cmd.out_sel  = SEL_PAY;
                            cmd.out_last = !sts.rem_one;
                            if (sts.rem_one) begin
                                state_next = ST_HCNT;
                            end
                        end
                    end
                end
            end
            ST_BODY, ST_OFF: begin
                if (sts.adv) begin
                    cmd.out_load  = 1'b1;
                    cmd.out_sel   = SEL_CUR;
                    cmd.cur_shift = 1'b1;
                    if (sts.cur_fits) begin
                        state_next = (state_reg == ST_BODY) ? ST_ATTR : ST_KEY;
                    end
                end
            end
            ST_ATTR: begin
                if (sts.adv) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = SEL_ZERO;
                    state_next   = ST_TS;
                end
            end
            ST_TS: begin
                if (sts.adv) begin
                    cmd.out_load     = 1'b1;
                    cmd.out_sel      = SEL_ZERO;
                    cmd.cur_load_off = 1'b1;
                    state_next       = ST_OFF;
                end
            end
            ST_KEY: begin
                if (sts.adv) begin
                    cmd.out_load     = 1'b1;
                    cmd.out_sel      = SEL_ZERO;
                    cmd.cur_load_len = 1'b1;
                    state_next       = ST_LEN;
                end
            end
            ST_LEN: begin
                if (sts.adv) begin
                    cmd.out_load  = 1'b1;
                    cmd.out_sel   = SEL_CUR;
                    cmd.cur_shift = 1'b1;
                    if (sts.cur_fits) begin
                        // an empty value closes the record with the header count
                        cmd.out_last = sts.rec_open;
                        state_next   = sts.rec_open ? ST_IDLE : ST_HCNT;
                    end
                end
            end
            ST_HCNT: begin
                if (sts.adv) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = SEL_ZERO;
                    cmd.out_end  = 1'b1;
                    cmd.out_last = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `RVE_ASSERT_IMP(a_busy_emits, (state_reg != ST_IDLE) && sts.adv, cmd.out_load, "busy stall")
    `RVE_ASSERT_NXT(a_empty_value_hcnt, len_empty_done, state_reg == ST_HCNT, "no header count")
    `RVE_ASSERT_IMP(a_ready_idle, s_tready, state_reg == ST_IDLE, "input ready outside idle")

endmodule

// ===== hw/rtl/rve_dp.sv =====
// ----------------------------------------------------------------------------
// Record varint encoder datapath
// Zigzag and length arithmetic, varint shifter, record counters, output beat.
// ----------------------------------------------------------------------------
`include "record_varint_encoder_top_assert.svh"

module rve_dp
    import rve_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [63:0] s_tdata,
    input  rve_cmd_t    cmd,
    output rve_sts_t    sts,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,
    output logic        m_tlast,
    output logic [1:0]  m_tuser
);

    logic [31:0] hdr_off;
    logic [23:0] hdr_len;
    logic [7:0]  payload_byte;

    logic [31:0] zoff;
    logic [24:0] zlen;
    logic [24:0] body;

    logic [31:0] cur_reg;
    logic [31:0] cur_next;
    logic [31:0] off_reg;
    logic [24:0] len_reg;
    logic [23:0] rem_reg;
    logic [23:0] rem_next;
    logic        open_reg;
    logic        open_next;

    logic        m_tvalid_reg;
    logic [7:0]  out_byte_reg;
    logic        out_end_reg;
    logic        out_last_reg;
    logic        out_err_reg;
    logic [7:0]  byte_sel;
    logic        err_beat_ok;

    assign hdr_off      = s_tdata[31:0];
    assign hdr_len      = s_tdata[55:32];
    assign payload_byte = s_tdata[63:56];

    assign zoff = {hdr_off[30:0], 1'b0} ^ {32{hdr_off[31]}};
    assign zlen = {hdr_len, 1'b0};
    assign body = 25'd4 + {22'd0, varint_len(zoff)} + {22'd0, varint_len({7'd0, zlen})}
                + {1'b0, hdr_len};

    assign sts.adv      = !m_tvalid_reg || m_tready;
    assign sts.rec_open = open_reg;
    assign sts.rem_zero = (rem_reg == 24'd0);
    assign sts.rem_one  = (rem_reg == 24'd1);
    assign sts.cur_fits = (cur_reg[31:7] == 25'd0);
    assign sts.vlen_bad = (hdr_len > MAX_VALUE_BYTES);

    always_comb begin
        cur_next = cur_reg;
        if (cmd.hdr_load) begin
            cur_next = {5'd0, body, 2'b0} >> 1;
        end else if (cmd.cur_load_off) begin
            cur_next = off_reg;
        end else if (cmd.cur_load_len) begin
            cur_next = {7'd0, len_reg};
        end else if (cmd.cur_shift) begin
            cur_next = {7'd0, cur_reg[31:7]};
        end
    end

    always_comb begin
        rem_next  = rem_reg;
        open_next = open_reg;
        if (cmd.hdr_load) begin
            rem_next  = hdr_len;
            open_next = (hdr_len != 24'd0);
        end else if (cmd.pay_take) begin
            rem_next = rem_reg - 24'd1;
            if (rem_reg == 24'd1) begin
                open_next = 1'b0;
            end
        end
    end

    always_comb begin
        case (cmd.out_sel)
            SEL_CUR:  byte_sel = {!sts.cur_fits, cur_reg[6:0]};
            SEL_PAY:  byte_sel = payload_byte;
            default:  byte_sel = 8'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        if (cmd.hdr_load) begin
            off_reg <= zoff;
            len_reg <= zlen;
        end
        if (cmd.out_load) begin
            out_byte_reg <= byte_sel;
            out_end_reg  <= cmd.out_end;
            out_last_reg <= cmd.out_last;
            out_err_reg  <= (cmd.out_sel == SEL_ERR);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg      <= 24'd0;
            open_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            rem_reg  <= rem_next;
            open_reg <= open_next;
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_end_reg;
    assign m_tuser  = {out_err_reg, out_last_reg};

    assign err_beat_ok = (out_byte_reg == 8'd0) && !out_end_reg && out_last_reg;

    `RVE_ASSERT(a_open_matches_count, open_reg == (rem_reg != 24'd0), "open flag vs byte count")
    `RVE_ASSERT_IMP(a_err_beat_shape, m_tvalid && out_err_reg, err_beat_ok, "malformed error beat")
    `RVE_ASSERT_IMP(a_end_is_last, m_tvalid && m_tlast, m_tuser[0], "record end without item end")

endmodule

// ===== hw/rtl/record_varint_encoder_top.sv =====
// ----------------------------------------------------------------------------
// Record varint encoder, top level
// Serializes log records as zigzag varint byte streams.
// ----------------------------------------------------------------------------
// A header beat (s_tuser 0) produces the body length varint, attributes 0x00,
// timestamp delta 0x00, the offset varint, key length 0x00 and the value
// length varint: 6 to 16 bytes, one per cycle unless the output stalls,
// through a single output register after the header is latched, plus the
// closing header count byte when the value is empty.
// Value beats (s_tuser 1) stream one per cycle unless the output stalls;
// the last value beat is followed by the closing 0x00 with m_tlast before the
// next beat is taken. An out-of-order beat is dropped and answered with one
// beat of 0x00 with m_tuser[1] set. Output stalls back-pressure the input.
module record_varint_encoder_top
    import rve_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // offset[31:0], length[55:32], payload[63:56]
    input  logic        s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte[7:0]
    output logic        m_tlast,   // record_end
    output logic [1:0]  m_tuser    // last_of_item[0], order_error[1]
);

    rve_cmd_t cmd;
    rve_sts_t sts;

    rve_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rve_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
